// ===== sv/lfuc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfuc_pkg
// shared constants for the lfu cache with lru tie break
// ----------------------------------------------------------------------------
`default_nettype none

package lfuc_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 5;

  // capacity register after reset
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // read value on a get miss
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

endpackage

`default_nettype wire

// ===== sv/lfuc_entry_ram.sv =====
// ----------------------------------------------------------------------------
// lfuc_entry_ram
// entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lfuc_entry_ram
  import lfuc_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = 4,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/lfu_cache_lru_tiebreak_unit.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_unit
// fully associative key-value cache, least-frequently-used replacement with
// least-recently-used tie break, entries held in one synchronous ram
// ----------------------------------------------------------------------------
//
//  channel  ports                                   transfer when
//  -------  --------------------------------------  --------------------------
//  input    in_action in_lookup_key in_write_value  start high, busy low
//  result   out_hit out_read_value out_evicted      out_valid high (one cycle)
//           out_evicted_key
//  config   cfg_we cfg_wdata                        cfg_we high
//
//  an item takes one scan pass over all CAPACITY ram entries, through the
//  ram read latency stage, then the decide step and, when the state
//  changes, one read-modify-write pass over all entries on the single ram
//  read port. the result comes out after the decide step; busy stays high
//  until the update pass ends, so a new item waits for it. valid bits and
//  occupancy clear at reset, the ram does not. the receiver cannot stall,
//  so no result is ever held back
//
`default_nettype none

module lfu_cache_lru_tiebreak_unit
  import lfuc_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_action,
  input  wire logic signed [DATA_W-1:0] in_lookup_key,
  input  wire logic signed [DATA_W-1:0] in_write_value,
  // result channel
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed      [DATA_W-1:0] out_read_value,
  output logic                          out_evicted,
  output logic signed      [DATA_W-1:0] out_evicted_key,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic        [CFG_W-1:0]  cfg_wdata
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [DATA_W-1:0]     key;
    logic [DATA_W-1:0]     value;
    logic [COUNT_BITS-1:0] cnt;
    logic [IW-1:0]         rank;  // 0 = most recently touched
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_UPD    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration register
  logic [CFG_W-1:0] cap_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_cfg_r <= cfg_wdata;
    end
  end

  // valid bits and occupancy live in flops
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;

  // captured item
  logic              act_r;
  logic [DATA_W-1:0] key_r, wval_r;

  // read stream: issue stage and ram read latency stage
  logic          iss_r, iss_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          pv_r;
  logic [IW-1:0] pidx_r;
  logic [REC_W-1:0] rdata;
  rec_t          q;

  // scan results
  logic              hit_r, hit_nxt;
  logic [IW-1:0]     hslot_r, hslot_nxt;
  logic [IW-1:0]     hrank_r, hrank_nxt;
  logic [DATA_W-1:0] hval_r, hval_nxt;
  logic              vfound_r, vfound_nxt;
  logic [IW-1:0]     vslot_r, vslot_nxt;
  logic [COUNT_BITS-1:0] vcnt_r, vcnt_nxt;
  logic [IW-1:0]     vrank_r, vrank_nxt;
  logic [DATA_W-1:0] vkey_r, vkey_nxt;
  logic              ffound_r, ffound_nxt;
  logic [IW-1:0]     fslot_r, fslot_nxt;

  // update plan
  logic          ins_r, ins_nxt;    // insert (else touch)
  logic          ev_r, ev_nxt;
  logic [IW-1:0] tslot_r, tslot_nxt;

  // result registers
  logic              ov_r, ov_nxt;
  logic              oh_r, oh_nxt;
  logic [DATA_W-1:0] ord_r, ord_nxt;
  logic              oe_r, oe_nxt;
  logic [DATA_W-1:0] oek_r, oek_nxt;

  // ram write side
  logic          we;
  logic [IW-1:0] waddr;
  rec_t          wrec;

  logic accept;
  logic pass_done;
  logic [31:0] cap_eff, occ32;
  logic ev_c;
  logic ent_valid;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign pass_done = pv_r && (pidx_r == LAST);
  assign q         = rec_t'(rdata);
  assign ent_valid = valid_r[pidx_r];

  // effective capacity saturates at CAPACITY
  assign cap_eff = (32'(cap_cfg_r) > 32'(CAPACITY)) ? 32'(CAPACITY) : 32'(cap_cfg_r);
  assign occ32   = 32'(occ_r);
  assign ev_c    = (occ32 >= cap_eff) && vfound_r;

  lfuc_entry_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW),
    .WIDTH (REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (REC_W'(wrec)),
    .re    (iss_r),
    .raddr (idx_r),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    iss_nxt    = iss_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    occ_nxt    = occ_r;
    hit_nxt    = hit_r;
    hslot_nxt  = hslot_r;
    hrank_nxt  = hrank_r;
    hval_nxt   = hval_r;
    vfound_nxt = vfound_r;
    vslot_nxt  = vslot_r;
    vcnt_nxt   = vcnt_r;
    vrank_nxt  = vrank_r;
    vkey_nxt   = vkey_r;
    ffound_nxt = ffound_r;
    fslot_nxt  = fslot_r;
    ins_nxt    = ins_r;
    ev_nxt     = ev_r;
    tslot_nxt  = tslot_r;
    ov_nxt     = 1'b0;
    oh_nxt     = oh_r;
    ord_nxt    = ord_r;
    oe_nxt     = oe_r;
    oek_nxt    = oek_r;
    we         = 1'b0;
    waddr      = pidx_r;
    wrec       = q;

    // issue side of the read stream
    if (iss_r) begin
      if (idx_r == LAST) begin
        iss_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IW'(1);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt  = ST_SCAN;
          iss_nxt    = 1'b1;
          idx_nxt    = '0;
          hit_nxt    = 1'b0;
          vfound_nxt = 1'b0;
          ffound_nxt = 1'b0;
        end
      end

      ST_SCAN: begin
        if (pv_r) begin
          if (ent_valid) begin
            if (!hit_r && (q.key == key_r)) begin
              hit_nxt   = 1'b1;
              hslot_nxt = pidx_r;
              hrank_nxt = q.rank;
              hval_nxt  = q.value;
            end
            // lowest count, then oldest
            if (!vfound_r || (q.cnt < vcnt_r) ||
                ((q.cnt == vcnt_r) && (q.rank > vrank_r))) begin
              vfound_nxt = 1'b1;
              vslot_nxt  = pidx_r;
              vcnt_nxt   = q.cnt;
              vrank_nxt  = q.rank;
              vkey_nxt   = q.key;
            end
          end else if (!ffound_r) begin
            ffound_nxt = 1'b1;
            fslot_nxt  = pidx_r;
          end
          if (pass_done) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        ov_nxt    = 1'b1;
        oh_nxt    = 1'b0;
        ord_nxt   = '0;
        oe_nxt    = 1'b0;
        oek_nxt   = '0;
        state_nxt = ST_IDLE;
        if (act_r == ACT_GET) begin
          if (hit_r) begin
            oh_nxt    = 1'b1;
            ord_nxt   = hval_r;
            ins_nxt   = 1'b0;
            tslot_nxt = hslot_r;
            state_nxt = ST_UPD;
          end else begin
            ord_nxt = MISS_VALUE;
          end
        end else if (cap_eff != 32'd0) begin
          if (hit_r) begin
            oh_nxt    = 1'b1;
            ins_nxt   = 1'b0;
            tslot_nxt = hslot_r;
            state_nxt = ST_UPD;
          end else if (ev_c || ffound_r) begin
            ins_nxt = 1'b1;
            ev_nxt  = ev_c;
            oe_nxt  = ev_c;
            if (ev_c) begin
              oek_nxt = vkey_r;
              valid_nxt[vslot_r] = 1'b0;
            end
            // lowest free slot after the eviction
            if (ev_c && (!ffound_r || (vslot_r < fslot_r))) begin
              tslot_nxt = vslot_r;
              valid_nxt[vslot_r] = 1'b1;
            end else begin
              tslot_nxt = fslot_r;
              valid_nxt[fslot_r] = 1'b1;
            end
            if (!ev_c) begin
              occ_nxt = occ_r + OW'(1);
            end
            state_nxt = ST_UPD;
          end
        end
        if (state_nxt == ST_UPD) begin
          iss_nxt = 1'b1;
          idx_nxt = '0;
        end
      end

      ST_UPD: begin
        if (pv_r) begin
          if (pidx_r == tslot_r) begin
            we        = 1'b1;
            wrec.rank = '0;
            if (ins_r) begin
              wrec.key   = key_r;
              wrec.value = wval_r;
              wrec.cnt   = COUNT_BITS'(1);
            end else begin
              if (act_r == ACT_PUT) begin
                wrec.value = wval_r;
              end
              if (q.cnt != COUNT_MAX) begin
                wrec.cnt = q.cnt + COUNT_BITS'(1);
              end
            end
          end else if (ent_valid) begin
            we = 1'b1;
            if (ins_r) begin
              if (ev_r && (q.rank > vrank_r)) begin
                wrec.rank = q.rank;
              end else begin
                wrec.rank = q.rank + IW'(1);
              end
            end else if (q.rank < hrank_r) begin
              wrec.rank = q.rank + IW'(1);
            end
          end
          if (pass_done) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iss_r   <= 1'b0;
      pv_r    <= 1'b0;
      valid_r <= '0;
      occ_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
      pv_r    <= iss_r;
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pidx_r   <= idx_r;
    hit_r    <= hit_nxt;
    hslot_r  <= hslot_nxt;
    hrank_r  <= hrank_nxt;
    hval_r   <= hval_nxt;
    vfound_r <= vfound_nxt;
    vslot_r  <= vslot_nxt;
    vcnt_r   <= vcnt_nxt;
    vrank_r  <= vrank_nxt;
    vkey_r   <= vkey_nxt;
    ffound_r <= ffound_nxt;
    fslot_r  <= fslot_nxt;
    ins_r    <= ins_nxt;
    ev_r     <= ev_nxt;
    tslot_r  <= tslot_nxt;
    oh_r     <= oh_nxt;
    ord_r    <= ord_nxt;
    oe_r     <= oe_nxt;
    oek_r    <= oek_nxt;
    if (accept) begin
      act_r  <= in_action;
      key_r  <= in_lookup_key;
      wval_r <= in_write_value;
    end
  end

  assign out_valid       = ov_r;
  assign out_hit         = oh_r;
  assign out_read_value  = ord_r;
  assign out_evicted     = oe_r;
  assign out_evicted_key = oek_r;

  // occupancy tracks the valid bits
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(occ_r))
    else $error("occupancy differs from valid bit count");

  // an eviction only comes from a put that missed
  a_evict_put: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit && (out_read_value == '0))
    else $error("eviction reported with hit or read value");

  // an accepted transfer keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  // every result follows a finished scan
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DECIDE))
    else $error("result without a decide step");

endmodule

`default_nettype wire
